>>> hw/rtl/ufd_pkg.sv
// Shared types, codes and the CRC-16 byte step for the frame deframer.
// No dependencies; imported by every module of the block.
`default_nettype none

package ufd_pkg;

  localparam int unsigned MAX_PAYLOAD_DEF = 32;
  // payload count width, fixed by the payload_len field
  localparam int unsigned CNT_W = 6;
  localparam logic [15:0] LEN_OVERHEAD = 16'd2;

  localparam logic [7:0]  HEADER_RST = 8'hAA;
  localparam logic [7:0]  TAIL_RST   = 8'h55;
  localparam logic [15:0] POLY_RST   = 16'hA001;
  localparam logic [15:0] START_RST  = 16'hFFFF;

  typedef enum logic [1:0] {
    FN_BYTE    = 2'd0,
    FN_TIMEOUT = 2'd1,
    FN_RESET   = 2'd2
  } func_e;

  typedef enum logic [2:0] {
    ST_HEADER  = 3'd0,
    ST_PAYLOAD = 3'd1,
    ST_SYNC    = 3'd2,
    ST_LENGTH  = 3'd3,
    ST_TAIL    = 3'd4,
    ST_CRC     = 3'd5,
    ST_TIMEOUT = 3'd6
  } status_e;

  typedef enum logic [1:0] {
    CFG_HEADER = 2'd0,
    CFG_TAIL   = 2'd1,
    CFG_POLY   = 2'd2,
    CFG_START  = 2'd3
  } cfg_reg_e;

  typedef enum logic [3:0] {
    PS_IDLE,
    PS_LEN1,
    PS_LEN2,
    PS_CLASS,
    PS_CMD,
    PS_DATA,
    PS_CRC1,
    PS_CRC2,
    PS_TAIL,
    PS_DRAIN
  } parse_state_e;

  typedef struct packed {
    logic [1:0] func;
    logic [7:0] rx_byte;
  } ufd_in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  frame_class;
    logic [7:0]  cmd_code;
    logic [5:0]  payload_len;
    logic [15:0] frame_crc;
    logic [7:0]  payload_byte;
    logic        last;
  } ufd_out_t;

  // controller -> datapath
  typedef struct packed {
    logic    clear_ctx;
    logic    cap_len_lo;
    logic    cap_len_hi;
    logic    cap_class;
    logic    cap_cmd;
    logic    cap_data;
    logic    cap_crc_lo;
    logic    cap_crc_hi;
    logic    out_load;
    status_e out_status;
    logic    drain_start;
    logic    drain_step;
  } ufd_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic out_free;
    logic hdr_match;
    logic tail_match;
    logic crc_match;
    logic len_ok;
    logic has_payload;
    logic data_last;
    logic drain_last;
  } ufd_sts_t;

  // reflected CRC-16, one byte, LSB first
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc,
                                             input logic [7:0]  data,
                                             input logic [15:0] poly);
    logic [15:0] c;
    c = crc ^ {8'h00, data};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ poly) : (c >> 1);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/ufd_ctrl.sv
// Parse controller: frame phase state machine and input back-pressure.
// Depends on ufd_pkg; drives the datapath through ufd_cmd_t.
`default_nettype none

module ufd_ctrl
  import ufd_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  logic [1:0] in_func_i,
  input  ufd_sts_t sts_i,
  output logic     in_stall_o,
  output ufd_cmd_t cmd_o
);

  parse_state_e state_q, state_d;
  logic         accept;

  assign in_stall_o = (state_q == PS_DRAIN) || !sts_i.out_free;
  assign accept     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= PS_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    if (state_q == PS_DRAIN) begin
      if (sts_i.out_free && sts_i.drain_last) begin
        state_d = PS_IDLE;
      end
    end else if (accept) begin
      unique case (in_func_i)
        FN_RESET:   state_d = PS_IDLE;
        FN_TIMEOUT: state_d = PS_IDLE;
        FN_BYTE: begin
          unique case (state_q)
            PS_IDLE:  state_d = sts_i.hdr_match ? PS_LEN1 : PS_IDLE;
            PS_LEN1:  state_d = PS_LEN2;
            PS_LEN2:  state_d = sts_i.len_ok ? PS_CLASS : PS_IDLE;
            PS_CLASS: state_d = PS_CMD;
            PS_CMD:   state_d = sts_i.has_payload ? PS_DATA : PS_CRC1;
            PS_DATA:  state_d = sts_i.data_last ? PS_CRC1 : PS_DATA;
            PS_CRC1:  state_d = PS_CRC2;
            PS_CRC2:  state_d = PS_TAIL;
            PS_TAIL: begin
              if (sts_i.tail_match && sts_i.crc_match && sts_i.has_payload) begin
                state_d = PS_DRAIN;
              end else begin
                state_d = PS_IDLE;
              end
            end
            default:  state_d = PS_IDLE;
          endcase
        end
        default: ;
      endcase
    end
  end

  // datapath commands
  always_comb begin
    cmd_o = '0;
    if (state_q == PS_DRAIN) begin
      cmd_o.out_status = ST_PAYLOAD;
      cmd_o.out_load   = sts_i.out_free;
      cmd_o.drain_step = sts_i.out_free;
    end else if (accept) begin
      unique case (in_func_i)
        FN_RESET: cmd_o.clear_ctx = 1'b1;
        FN_TIMEOUT: begin
          // ignore a timeout between frames
          if (state_q != PS_IDLE) begin
            cmd_o.out_load   = 1'b1;
            cmd_o.out_status = ST_TIMEOUT;
          end
        end
        FN_BYTE: begin
          unique case (state_q)
            PS_IDLE: begin
              if (sts_i.hdr_match) begin
                cmd_o.clear_ctx = 1'b1;
              end else begin
                cmd_o.out_load   = 1'b1;
                cmd_o.out_status = ST_SYNC;
              end
            end
            PS_LEN1: cmd_o.cap_len_lo = 1'b1;
            PS_LEN2: begin
              cmd_o.cap_len_hi = 1'b1;
              if (!sts_i.len_ok) begin
                cmd_o.out_load   = 1'b1;
                cmd_o.out_status = ST_LENGTH;
              end
            end
            PS_CLASS: cmd_o.cap_class  = 1'b1;
            PS_CMD:   cmd_o.cap_cmd    = 1'b1;
            PS_DATA:  cmd_o.cap_data   = 1'b1;
            PS_CRC1:  cmd_o.cap_crc_lo = 1'b1;
            PS_CRC2:  cmd_o.cap_crc_hi = 1'b1;
            PS_TAIL: begin
              cmd_o.out_load = 1'b1;
              // tail is checked before the CRC
              priority if (!sts_i.tail_match) begin
                cmd_o.out_status = ST_TAIL;
              end else if (!sts_i.crc_match) begin
                cmd_o.out_status = ST_CRC;
              end else begin
                cmd_o.out_status  = ST_HEADER;
                cmd_o.drain_start = 1'b1;
              end
            end
            default: ;
          endcase
        end
        default: ;
      endcase
    end
  end

  a_load_needs_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> sts_i.out_free)
    else $error("result loaded while output register is occupied");

  a_drain_ends_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == PS_DRAIN && cmd_o.drain_step && sts_i.drain_last) |=> state_q == PS_IDLE)
    else $error("drain did not return to idle after last payload byte");

  a_data_has_payload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == PS_DATA |-> sts_i.has_payload)
    else $error("payload phase entered for an empty frame");

endmodule

`default_nettype wire

>>> hw/rtl/ufd_dpath.sv
// Datapath: configuration registers, frame context, running CRC, payload
// memory and the output register. Depends on ufd_pkg; driven by ufd_ctrl.
`default_nettype none

module ufd_dpath
  import ufd_pkg::*;
#(
  parameter int unsigned MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [7:0]  rx_byte_i,
  input  ufd_cmd_t    cmd_i,
  output ufd_sts_t    sts_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output ufd_out_t    out_data_o
);

  localparam int unsigned AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
  localparam logic [15:0] LEN_MAX = 16'(MAX_PAYLOAD + 2);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_PAYLOAD);

  logic [7:0]  header_q, tail_q;
  logic [15:0] poly_q, start_q;

  logic [7:0]       len_lo_q;
  logic [CNT_W-1:0] dlen_q;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [15:0]      crc_q, crc_d;
  logic [15:0]      rcv_crc_q;
  logic [7:0]       class_q, cmd_q;

  logic [7:0]       pay_mem_q [MAX_PAYLOAD];
  logic [7:0]       rd_data_q;
  logic [CNT_W-1:0] rd_ptr_q, rd_ptr_d;
  logic             rd_en;

  logic     out_valid_q;
  ufd_out_t out_data_q, out_d;
  logic [15:0] len_full;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      header_q <= HEADER_RST;
      tail_q   <= TAIL_RST;
      poly_q   <= POLY_RST;
      start_q  <= START_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_HEADER: header_q <= cfg_data_i[7:0];
        CFG_TAIL:   tail_q   <= cfg_data_i[7:0];
        CFG_POLY:   poly_q   <= cfg_data_i;
        CFG_START:  start_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign len_full = {rx_byte_i, len_lo_q};

  always_comb begin
    crc_d = crc_q;
    if (cmd_i.clear_ctx) begin
      crc_d = start_q;
    end else if (cmd_i.cap_class || cmd_i.cap_cmd || cmd_i.cap_data) begin
      crc_d = crc16_byte(crc_q, rx_byte_i, poly_q);
    end
  end

  always_comb begin
    cnt_d = cnt_q;
    if (cmd_i.clear_ctx || cmd_i.cap_cmd) begin
      cnt_d = '0;
    end else if (cmd_i.cap_data) begin
      cnt_d = cnt_q + CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_lo_q  <= '0;
      dlen_q    <= '0;
      cnt_q     <= '0;
      crc_q     <= START_RST;
      rcv_crc_q <= '0;
      class_q   <= '0;
      cmd_q     <= '0;
    end else begin
      cnt_q <= cnt_d;
      crc_q <= crc_d;
      if (cmd_i.clear_ctx) begin
        len_lo_q  <= '0;
        dlen_q    <= '0;
        rcv_crc_q <= '0;
        class_q   <= '0;
        cmd_q     <= '0;
      end else begin
        if (cmd_i.cap_len_lo) len_lo_q <= rx_byte_i;
        // only meaningful when the length passes its range check
        if (cmd_i.cap_len_hi) dlen_q <= CNT_W'(len_full - LEN_OVERHEAD);
        if (cmd_i.cap_class)  class_q <= rx_byte_i;
        if (cmd_i.cap_cmd)    cmd_q <= rx_byte_i;
        if (cmd_i.cap_crc_lo) rcv_crc_q[7:0] <= rx_byte_i;
        if (cmd_i.cap_crc_hi) rcv_crc_q[15:8] <= rx_byte_i;
      end
    end
  end

  // payload drain read pointer; data for the next result is read ahead into rd_data_q
  always_comb begin
    rd_ptr_d = rd_ptr_q;
    if (cmd_i.drain_start) begin
      rd_ptr_d = '0;
    end else if (cmd_i.drain_step) begin
      rd_ptr_d = rd_ptr_q + CNT_W'(1);
    end
  end

  assign rd_en = rd_ptr_d < CNT_MAX;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_ptr_q <= '0;
    end else begin
      rd_ptr_q <= rd_ptr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap_data) begin
      pay_mem_q[cnt_q[AW-1:0]] <= rx_byte_i;
    end
    if (rd_en) begin
      rd_data_q <= pay_mem_q[rd_ptr_d[AW-1:0]];
    end
  end

  assign sts_o.out_free    = !out_valid_q || !out_stall_i;
  assign sts_o.hdr_match   = rx_byte_i == header_q;
  assign sts_o.tail_match  = rx_byte_i == tail_q;
  assign sts_o.crc_match   = crc_q == rcv_crc_q;
  assign sts_o.len_ok      = (len_full >= LEN_OVERHEAD) && (len_full <= LEN_MAX);
  assign sts_o.has_payload = dlen_q != '0;
  assign sts_o.data_last   = (cnt_q + CNT_W'(1)) == dlen_q;
  assign sts_o.drain_last  = (rd_ptr_q + CNT_W'(1)) == cnt_q;

  always_comb begin
    out_d        = '0;
    out_d.status = cmd_i.out_status;
    unique case (cmd_i.out_status)
      ST_HEADER: begin
        out_d.frame_class = class_q;
        out_d.cmd_code    = cmd_q;
        out_d.payload_len = cnt_q;
        out_d.frame_crc   = rcv_crc_q;
        out_d.last        = cnt_q == '0;
      end
      ST_PAYLOAD: begin
        out_d.payload_byte = rd_data_q;
        out_d.last         = sts_o.drain_last;
      end
      default: out_d.last = 1'b1;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_data_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_MAX)
    else $error("payload count beyond store depth");

  a_write_in_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.cap_data |-> cnt_q < dlen_q)
    else $error("payload write beyond frame length");

  a_drain_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.drain_step |-> rd_ptr_q < cnt_q)
    else $error("drain read beyond stored payload");

endmodule

`default_nettype wire

>>> hw/rtl/uart_frame_deframer_crc16_core.sv
// A result is in the output register in the cycle after the input that causes it.
// Throughput: one input per cycle outside the payload drain while the output register is
// free or being taken. A good frame with N payload bytes gives N+1 results, one per
// cycle unless the output stalls; input waits during the drain (payload memory read port).
// Reset (rst_ni, async low) returns to idle and restores register defaults; no clear pass.
// Top level of the frame deframer; depends on ufd_pkg, ufd_ctrl and ufd_dpath.
`default_nettype none

module uart_frame_deframer_crc16_core
  import ufd_pkg::*;
#(
  parameter int unsigned MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  ufd_in_t     in_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output ufd_out_t    out_data_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  ufd_cmd_t cmd;
  ufd_sts_t sts;

  ufd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_func_i  (in_data_i.func),
    .sts_i      (sts),
    .in_stall_o (in_stall_o),
    .cmd_o      (cmd)
  );

  ufd_dpath #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rx_byte_i   (in_data_i.rx_byte),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire
